### hw/rtl/msbpk_pkg.sv
package msbpk_pkg;

  // Width of the code field and the saturation bound it implies
  localparam int unsigned CodeW        = 16;
  localparam int unsigned CntW         = 5;
  localparam int unsigned MaxCodeWidth = 16;

  // Partial-byte accumulator: up to seven gathered bits
  localparam int unsigned PartW = 7;
  localparam int unsigned PcntW = 3;
  // Accumulator plus one full code
  localparam int unsigned AccW  = PartW + CodeW;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CntW-1:0]  bit_count;
    logic [CodeW-1:0] code_value;
    logic             low_bit_first;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Mirror a code word end for end
  function automatic logic [CodeW-1:0] rev_code(input logic [CodeW-1:0] v);
    logic [CodeW-1:0] r;
    for (int unsigned i = 0; i < CodeW; i++) begin
      r[i] = v[CodeW-1-i];
    end
    return r;
  endfunction

endpackage

### hw/rtl/msbpk_if.sv
// Input beat channel
interface msbpk_in_if;
  logic                 valid;
  logic                 ready;
  msbpk_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Output byte channel
interface msbpk_out_if;
  logic                 valid;
  logic                 ready;
  msbpk_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/msb_first_bit_packer.sv
// A beat is registered on input and its bytes again on output. One beat is
// taken per cycle when it yields at most one byte and out_o does not stall; a
// two-byte beat holds the input until its second byte leaves the pending-byte
// register. Reset (async, active low) empties the input, output and
// pending-byte registers and clears the partial-byte accumulator.
module msb_first_bit_packer #(
  parameter int unsigned MAX_CODE_WIDTH = msbpk_pkg::MaxCodeWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  msbpk_in_if.sink           in_i,
  msbpk_out_if.source        out_o
);

  localparam int unsigned CodeW = msbpk_pkg::CodeW;
  localparam int unsigned CntW  = msbpk_pkg::CntW;
  localparam int unsigned PartW = msbpk_pkg::PartW;
  localparam int unsigned PcntW = msbpk_pkg::PcntW;
  localparam int unsigned AccW  = msbpk_pkg::AccW;
  localparam logic [CntW-1:0] CntLimit =
    CntW'((MAX_CODE_WIDTH < CodeW) ? MAX_CODE_WIDTH : CodeW);

  // Input register
  logic                in_valid_q;
  msbpk_pkg::in_item_t in_item_q;

  // Accumulator state
  logic [PartW-1:0] part_q, part_d;
  logic [PcntW-1:0] pcnt_q, pcnt_d;

  // Output register and second-byte holding register
  logic                 out_valid_q, out_valid_d;
  msbpk_pkg::out_item_t out_item_q, out_item_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [7:0]           pend_byte_q, pend_byte_d;

  logic consume;
  logic out_fire;

  assign out_fire = out_valid_q && out_o.ready;
  // The buffered beat is processed once its bytes have somewhere to go
  assign consume  = in_valid_q && !pend_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || consume;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // Bit gathering datapath
  logic [CntW-1:0]  cnt;
  logic [CodeW-1:0] code_msb, code_lsb, code;
  logic [AccW-1:0]  acc;
  logic [CntW-1:0]  total;
  logic [7:0]       byte0, byte1, flush_byte;
  logic [7:0]       rem_mask;

  always_comb begin
    cnt      = (in_item_q.bit_count > CntLimit) ? CntLimit : in_item_q.bit_count;
    code_msb = in_item_q.code_value &
               CodeW'(({1'b0, {CodeW{1'b1}}} << cnt) ^ {1'b0, {CodeW{1'b1}}});
    code_lsb = msbpk_pkg::rev_code(in_item_q.code_value) >> (CntW'(CodeW) - cnt);
    code     = in_item_q.low_bit_first ? code_lsb : code_msb;
    acc      = ({{CodeW{1'b0}}, part_q} << cnt) | {{PartW{1'b0}}, code};
    total    = {{(CntW-PcntW){1'b0}}, pcnt_q} + cnt;
    byte0    = 8'(acc >> (total - CntW'(8)));
    byte1    = 8'(acc >> (total - CntW'(16)));
    rem_mask = 8'((9'd1 << total[PcntW-1:0]) - 9'd1);
    flush_byte = 8'({1'b0, part_q} << (4'd8 - {1'b0, pcnt_q}));
  end

  // Next state of accumulator and output registers
  always_comb begin
    part_d       = part_q;
    pcnt_d       = pcnt_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    pend_valid_d = pend_valid_q;
    pend_byte_d  = pend_byte_q;

    if (out_fire) begin
      out_valid_d = pend_valid_q;
      if (pend_valid_q) begin
        out_item_d.out_byte = pend_byte_q;
        out_item_d.last     = 1'b1;
      end
      pend_valid_d = 1'b0;
    end

    if (consume) begin
      case (in_item_q.op)
        msbpk_pkg::OP_FLUSH: begin
          if (pcnt_q != '0) begin
            out_valid_d         = 1'b1;
            out_item_d.out_byte = flush_byte;
            out_item_d.last     = 1'b1;
          end
          part_d = '0;
          pcnt_d = '0;
        end
        msbpk_pkg::OP_WRITE: begin
          if (total >= CntW'(16)) begin
            out_valid_d         = 1'b1;
            out_item_d.out_byte = byte0;
            out_item_d.last     = 1'b0;
            pend_valid_d        = 1'b1;
            pend_byte_d         = byte1;
          end else if (total >= CntW'(8)) begin
            out_valid_d         = 1'b1;
            out_item_d.out_byte = byte0;
            out_item_d.last     = 1'b1;
          end
          part_d = acc[PartW-1:0] & rem_mask[PartW-1:0];
          pcnt_d = total[PcntW-1:0];
        end
        default: begin
          part_d = part_q;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
  end

  // Control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q       <= '0;
      pcnt_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      part_q       <= part_d;
      pcnt_q       <= pcnt_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    pend_byte_q <= pend_byte_d;
  end

  // A held second byte always sits behind a first byte on the port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending byte without an output byte");

  // The first of two bytes is never flagged last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !out_item_q.last)
    else $error("first of two bytes flagged last");

  // No beat is processed while a second byte is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !consume)
    else $error("beat processed over a held byte");

  // A flush leaves the accumulator empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_item_q.op == msbpk_pkg::OP_FLUSH) |=> (pcnt_q == '0 && part_q == '0))
    else $error("accumulator not empty after flush");

endmodule
